@@ src/bstp_pkg.sv @@
// Shared types, constants and phase table for the two-axis stepper driver.
package bstp_pkg;

  localparam int POS_W  = 16;
  localparam int SPAN_W = POS_W + 1;
  localparam int ERR_W  = POS_W + 2;
  localparam int DRV_W  = 4;
  localparam int IDLE_W = 8;

  localparam logic [IDLE_W-1:0] IDLE_RELOAD_RST = 8'd127;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [1:0] {
    KIND_GOTO  = 2'd0,
    KIND_STEP  = 2'd1,
    KIND_TIMER = 2'd2,
    KIND_ZERO  = 2'd3
  } kind_t;

  // One result item
  typedef struct packed {
    logic [DRV_W-1:0] x_drive;
    logic [DRV_W-1:0] y_drive;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             busy_res;
    logic             energized;
  } result_t;

  // Bridge pin pattern for one full-step phase: bit0 A+, bit1 A-, bit2 B+, bit3 B-
  function automatic logic [DRV_W-1:0] phase_pins(input logic [1:0] phase);
    logic [DRV_W-1:0] pins;
    unique case (phase)
      2'd0:    pins = 4'd9;
      2'd1:    pins = 4'd5;
      2'd2:    pins = 4'd6;
      default: pins = 4'd10;
    endcase
    return pins;
  endfunction

endpackage

@@ src/bstp_core.sv @@
// Motion state, Bresenham iteration and idle timeout for the stepper driver.
module bstp_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bstp_pkg::IDLE_W-1:0]   cfg_wr_data,
  input  logic                          req_en,
  input  bstp_pkg::kind_t               req_kind,
  input  logic [bstp_pkg::POS_W-1:0]    req_target_x,
  input  logic [bstp_pkg::POS_W-1:0]    req_target_y,
  output bstp_pkg::result_t             res_nxt
);
  import bstp_pkg::*;

  logic [IDLE_W-1:0]        idle_reload_r;
  logic [POS_W-1:0]         pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [POS_W-1:0]         goal_x_r, goal_x_nxt, goal_y_r, goal_y_nxt;
  logic [SPAN_W-1:0]        span_x_r, span_x_nxt, span_y_r, span_y_nxt;
  logic                     dir_x_r, dir_x_nxt, dir_y_r, dir_y_nxt;
  logic signed [ERR_W-1:0]  err_r, err_nxt;
  logic                     moving_r, moving_nxt;
  logic [1:0]               phase_x_r, phase_x_nxt, phase_y_r, phase_y_nxt;
  logic                     drv_x_r, drv_x_nxt, drv_y_r, drv_y_nxt;
  logic [IDLE_W-1:0]        idle_cnt_r, idle_cnt_nxt;
  logic                     armed_r, armed_nxt;

  logic signed [SPAN_W-1:0] diff_x, diff_y;
  logic [SPAN_W-1:0]        gspan_x, gspan_y;
  logic signed [ERR_W:0]    err_ext, sx_ext, sy_ext;
  logic                     step_x, step_y;
  logic signed [ERR_W:0]    err_sum;

  // Line setup from the current position to the new target
  always_comb begin
    diff_x  = SPAN_W'($signed(req_target_x)) - SPAN_W'($signed(pos_x_r));
    diff_y  = SPAN_W'($signed(req_target_y)) - SPAN_W'($signed(pos_y_r));
    gspan_x = diff_x[SPAN_W-1] ? SPAN_W'(-diff_x) : SPAN_W'(diff_x);
    gspan_y = diff_y[SPAN_W-1] ? SPAN_W'(-diff_y) : SPAN_W'(diff_y);
  end

  // One Bresenham iteration: decide which axes step and update the error
  always_comb begin
    err_ext = (ERR_W+1)'(err_r);
    sx_ext  = $signed({2'b00, span_x_r});
    sy_ext  = $signed({2'b00, span_y_r});
    step_x  = (err_ext + sx_ext) > 0;
    step_y  = err_ext < sy_ext;
    err_sum = err_ext - (step_y ? (ERR_W+1)'(0) : (ERR_W+1)'(0))
              - (step_x ? sy_ext : (ERR_W+1)'(0))
              + (step_y ? sx_ext : (ERR_W+1)'(0));
  end

  // Next state for the request
  always_comb begin
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    goal_x_nxt   = goal_x_r;
    goal_y_nxt   = goal_y_r;
    span_x_nxt   = span_x_r;
    span_y_nxt   = span_y_r;
    dir_x_nxt    = dir_x_r;
    dir_y_nxt    = dir_y_r;
    err_nxt      = err_r;
    moving_nxt   = moving_r;
    phase_x_nxt  = phase_x_r;
    phase_y_nxt  = phase_y_r;
    drv_x_nxt    = drv_x_r;
    drv_y_nxt    = drv_y_r;
    idle_cnt_nxt = idle_cnt_r;
    armed_nxt    = armed_r;
    unique case (req_kind)
      KIND_GOTO: begin
        goal_x_nxt = req_target_x;
        goal_y_nxt = req_target_y;
        span_x_nxt = gspan_x;
        span_y_nxt = gspan_y;
        dir_x_nxt  = !($signed(pos_x_r) < $signed(req_target_x));
        dir_y_nxt  = !($signed(pos_y_r) < $signed(req_target_y));
        err_nxt    = (gspan_x > gspan_y) ? $signed(ERR_W'(gspan_x >> 1))
                                         : -$signed(ERR_W'(gspan_y >> 1));
        moving_nxt = (pos_x_r != req_target_x) || (pos_y_r != req_target_y);
      end
      KIND_STEP: begin
        if (moving_r) begin
          err_nxt = ERR_W'(err_sum);
          if (step_x) begin
            pos_x_nxt   = dir_x_r ? pos_x_r - 1'b1 : pos_x_r + 1'b1;
            phase_x_nxt = dir_x_r ? phase_x_r + 1'b1 : phase_x_r - 1'b1;
            drv_x_nxt   = 1'b1;
          end
          if (step_y) begin
            pos_y_nxt   = dir_y_r ? pos_y_r - 1'b1 : pos_y_r + 1'b1;
            phase_y_nxt = dir_y_r ? phase_y_r + 1'b1 : phase_y_r - 1'b1;
            drv_y_nxt   = 1'b1;
          end
          if (step_x || step_y) begin
            idle_cnt_nxt = idle_reload_r;
            armed_nxt    = 1'b1;
          end
          if ((pos_x_nxt == goal_x_r) && (pos_y_nxt == goal_y_r)) begin
            moving_nxt = 1'b0;
          end
        end
      end
      KIND_TIMER: begin
        if (armed_r) begin
          if (idle_cnt_r != '0) begin
            idle_cnt_nxt = idle_cnt_r - 1'b1;
          end else begin
            armed_nxt   = 1'b0;
            drv_x_nxt   = 1'b0;
            drv_y_nxt   = 1'b0;
            phase_x_nxt = 2'd0;
            phase_y_nxt = 2'd0;
          end
        end
      end
      default: begin
        pos_x_nxt  = '0;
        pos_y_nxt  = '0;
        moving_nxt = 1'b0;
      end
    endcase
  end

  // Result seen after the request takes effect
  always_comb begin
    res_nxt.x_drive   = drv_x_nxt ? phase_pins(phase_x_nxt) : '0;
    res_nxt.y_drive   = drv_y_nxt ? phase_pins(phase_y_nxt) : '0;
    res_nxt.pos_x     = pos_x_nxt;
    res_nxt.pos_y     = pos_y_nxt;
    res_nxt.busy_res  = moving_nxt;
    res_nxt.energized = drv_x_nxt | drv_y_nxt;
  end

  // Hold the idle reload register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_reload_r <= IDLE_RELOAD_RST;
    end else if (cfg_wr_en) begin
      idle_reload_r <= cfg_wr_data;
    end
  end

  // Advance motion state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      goal_x_r   <= '0;
      goal_y_r   <= '0;
      span_x_r   <= '0;
      span_y_r   <= '0;
      dir_x_r    <= 1'b0;
      dir_y_r    <= 1'b0;
      err_r      <= '0;
      moving_r   <= 1'b0;
      phase_x_r  <= 2'd0;
      phase_y_r  <= 2'd0;
      drv_x_r    <= 1'b0;
      drv_y_r    <= 1'b0;
      idle_cnt_r <= '0;
      armed_r    <= 1'b0;
    end else if (req_en) begin
      pos_x_r    <= pos_x_nxt;
      pos_y_r    <= pos_y_nxt;
      goal_x_r   <= goal_x_nxt;
      goal_y_r   <= goal_y_nxt;
      span_x_r   <= span_x_nxt;
      span_y_r   <= span_y_nxt;
      dir_x_r    <= dir_x_nxt;
      dir_y_r    <= dir_y_nxt;
      err_r      <= err_nxt;
      moving_r   <= moving_nxt;
      phase_x_r  <= phase_x_nxt;
      phase_y_r  <= phase_y_nxt;
      drv_x_r    <= drv_x_nxt;
      drv_y_r    <= drv_y_nxt;
      idle_cnt_r <= idle_cnt_nxt;
      armed_r    <= armed_nxt;
    end
  end

endmodule

@@ src/bresenham_two_axis_stepper_driver_top.sv @@
// Top level of the two-axis Bresenham stepper driver with output register.
//
//  channel   dir  handshake            payload
//  in_*      in   tvalid/tready        tuser: kind; tdata: target_x, target_y
//  out_*     out  tvalid/tready        tdata: drives, positions, busy, energized
//  cfg_*     in   wr_en (no wait)      wr_data: idle_reload
//
// One request is accepted per cycle unless the output stalls; its result appears
// in the output register the following cycle. The input is ready whenever the output
// register is empty or being drained, so a stalled consumer holds the result and
// blocks new input. Reset (rst_n low, synchronous) clears positions, motion, phases
// and timeout, and sets idle_reload to 127.
module bresenham_two_axis_stepper_driver_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bstp_pkg::IN_TDATA_W-1:0]     in_tdata,  // target_x, target_y
  input  logic [bstp_pkg::IN_TUSER_W-1:0]     in_tuser,  // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // x_drive, y_drive, pos_x, pos_y, busy_res, energized, zero pad
  output logic [bstp_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_wr_en,
  input  logic [bstp_pkg::IDLE_W-1:0]         cfg_wr_data
);
  import bstp_pkg::*;

  logic     out_valid_r;
  result_t  res_r;
  result_t  res_nxt;
  logic     req_en;

  assign in_tready = !out_valid_r || out_tready;
  assign req_en    = in_tvalid && in_tready;

  bstp_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .req_en       (req_en),
    .req_kind     (kind_t'(in_tuser)),
    .req_target_x (in_tdata[POS_W-1:0]),
    .req_target_y (in_tdata[2*POS_W-1:POS_W]),
    .res_nxt      (res_nxt)
  );

  // Track whether the output register holds a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Capture the result of an accepted request
  always_ff @(posedge clk) begin
    if (req_en) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, res_r.energized, res_r.busy_res, res_r.pos_y, res_r.pos_x,
                       res_r.y_drive, res_r.x_drive};

endmodule
